FILE: src/hbu_pkg.sv
// Shared types and constants of the heightmap bilinear upsampler.
// Field widths, opcodes, register indexes and the configuration record.
// No dependencies.
package hbu_pkg;

  localparam int XW     = 12;  // vertex coordinate width
  localparam int EW     = 24;  // elevation width
  localparam int HTW    = 32;  // result height width
  localparam int GIW    = 9;   // grid row and column width
  localparam int CIDXW  = 3;   // configuration index width
  localparam int CDW    = 24;  // configuration data width

  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  localparam logic [CIDXW-1:0] REG_SUBSAMPLING    = 3'd0;
  localparam logic [CIDXW-1:0] REG_VERTEX_COUNT   = 3'd1;
  localparam logic [CIDXW-1:0] REG_GRID_SIDE      = 3'd2;
  localparam logic [CIDXW-1:0] REG_MIN_ELEVATION  = 3'd3;
  localparam logic [CIDXW-1:0] REG_VERTICAL_SCALE = 3'd4;
  localparam logic [CIDXW-1:0] REG_NEGATE_HEIGHT  = 3'd5;
  localparam logic [CIDXW-1:0] REG_FLIP_ROWS      = 3'd6;

  typedef struct packed {
    logic [4:0]         subsampling;
    logic [12:0]        vertex_count;
    logic [8:0]         grid_side;
    logic signed [23:0] min_elevation;
    logic signed [23:0] vertical_scale;
    logic               negate_height;
    logic               flip_rows;
  } cfg_t;

endpackage

FILE: src/hbu_if.sv
// Channel interfaces of the heightmap bilinear upsampler: request, response
// and configuration write. Depends on hbu_pkg.
interface hbu_req_if import hbu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [GIW-1:0]       grid_row;
  logic [GIW-1:0]       grid_col;
  logic signed [EW-1:0] elevation;
  logic [XW-1:0]        vertex_x;
  logic [XW-1:0]        vertex_y;
  modport source (output valid, opcode, grid_row, grid_col, elevation, vertex_x, vertex_y,
                  input ready);
  modport sink (input valid, opcode, grid_row, grid_col, elevation, vertex_x, vertex_y,
                output ready);
endinterface

interface hbu_rsp_if import hbu_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [HTW-1:0] height;
  logic [XW-1:0]         out_row;
  logic [XW-1:0]         out_col;
  modport source (output valid, height, out_row, out_col, input ready);
  modport sink (input valid, height, out_row, out_col, output ready);
endinterface

interface hbu_cfg_if import hbu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CIDXW-1:0] index;
  logic [CDW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/heightmap_bilinear_upsampler.sv
// Heightmap bilinear upsampler top level: configuration registers, index
// split, banked grid access, blend and scale pipeline, rounding divider.
// Depends on hbu_pkg, hbu_if, hbu_grid and hbu_div.
//
//   channel  dir  handshake      word
//   req      in   valid/ready    opcode, grid_row, grid_col, elevation, vertex_x, vertex_y
//   rsp      out  valid/ready    height, out_row, out_col
//   cfg      in   valid/ready    index, data (ready is always high)
//
// One word is accepted every cycle while the response channel is not stalled; a query's
// response word passes through seven arithmetic stages, the 33-stage divider
// (an input register, then one quotient bit per stage) and the output register.
// Grid writes complete in the third stage and give no response word.
// Reset is synchronous, clears valid bits and sets configuration to its defaults; the grid is
// not cleared. A stalled response holds the whole pipeline in place.
module heightmap_bilinear_upsampler import hbu_pkg::*; #(
  parameter int MAX_SIDE        = 257,
  parameter int MAX_SUBSAMPLING = 16
) (
  input logic     clk,
  input logic     rst,
  hbu_req_if.sink req,
  hbu_rsp_if.source rsp,
  hbu_cfg_if.sink cfg
);

  localparam int SBW    = $clog2(MAX_SUBSAMPLING + 1);
  localparam int S2W    = 2 * SBW;
  localparam int K      = XW + SBW;
  localparam int RCW    = K + 1;
  localparam int SDB    = $clog2(MAX_SIDE + 1);
  localparam int IW     = (SDB > XW ? SDB : XW) + 1;
  localparam int HALF   = (MAX_SIDE + 1) / 2;
  localparam int BDEPTH = HALF * HALF;
  localparam int BAW    = BDEPTH > 1 ? $clog2(BDEPTH) : 1;
  localparam int WA     = EW + SBW + 2;
  localparam int NW     = EW + 2 * SBW + 3;
  localparam int PHW    = NW + 12;
  localparam int PLW_M  = NW + 13;
  localparam int PW     = NW + 25;
  localparam int TW     = PW - 16;
  localparam int DPL    = 1 + 2 * XW;

  // Configuration registers.
  cfg_t cfg_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.subsampling    <= 5'd1;
      cfg_q.vertex_count   <= 13'd257;
      cfg_q.grid_side      <= 9'd257;
      cfg_q.min_elevation  <= '0;
      cfg_q.vertical_scale <= 24'sd65536;
      cfg_q.negate_height  <= 1'b0;
      cfg_q.flip_rows      <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SUBSAMPLING:    cfg_q.subsampling    <= cfg.data[4:0];
        REG_VERTEX_COUNT:   cfg_q.vertex_count   <= cfg.data[12:0];
        REG_GRID_SIDE:      cfg_q.grid_side      <= cfg.data[8:0];
        REG_MIN_ELEVATION:  cfg_q.min_elevation  <= cfg.data;
        REG_VERTICAL_SCALE: cfg_q.vertical_scale <= cfg.data;
        REG_NEGATE_HEIGHT:  cfg_q.negate_height  <= cfg.data[0];
        REG_FLIP_ROWS:      cfg_q.flip_rows      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Settled configuration values; the user must keep them constant while queries run (not enforced here).
  logic [7:0]     sub_w;
  logic [SBW-1:0] s_c;
  logic [S2W-1:0] s2_c;
  logic [IW-1:0]  side_w;
  logic [IW-1:0]  side_c;
  logic [IW-1:0]  smax;
  logic [RCW-1:0] recip_tab [MAX_SUBSAMPLING+1];
  logic [RCW-1:0] recip;

  assign sub_w  = 8'(cfg_q.subsampling);
  assign s_c    = (sub_w == 8'd0) ? SBW'(1) :
                  (sub_w > 8'(MAX_SUBSAMPLING)) ? SBW'(MAX_SUBSAMPLING) : SBW'(sub_w);
  assign s2_c   = {{SBW{1'b0}}, s_c} * {{SBW{1'b0}}, s_c};
  assign side_w = IW'(cfg_q.grid_side);
  assign side_c = (side_w < IW'(2)) ? IW'(2) :
                  (side_w > IW'(MAX_SIDE)) ? IW'(MAX_SIDE) : side_w;
  assign smax   = side_c - IW'(1);

  for (genvar g = 0; g <= MAX_SUBSAMPLING; g++) begin : g_recip
    localparam logic [RCW-1:0] RV = RCW'((2 ** K) / (g == 0 ? 1 : g));
    assign recip_tab[g] = RV;
  end
  assign recip = recip_tab[s_c];

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Stage 1: capture and multiply by the reciprocal of the factor.
  logic              v1;
  logic              op1;
  logic [GIW-1:0]    wrow1, wcol1;
  logic [EW-1:0]     elev1;
  logic [XW-1:0]     x1, y1;
  logic [XW+RCW-1:0] px1, py1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
    end
    if (en) begin
      op1   <= req.opcode;
      wrow1 <= req.grid_row;
      wcol1 <= req.grid_col;
      elev1 <= req.elevation;
      x1    <= req.vertex_x;
      y1    <= req.vertex_y;
      px1   <= {{RCW{1'b0}}, req.vertex_x} * {{XW{1'b0}}, recip};
      py1   <= {{RCW{1'b0}}, req.vertex_y} * {{XW{1'b0}}, recip};
    end
  end

  // Stage 2: the estimate is low by at most one; fix quotient and remainder.
  logic [XW-1:0]     qx0, qy0, rx0, ry0, sx;
  logic [XW+SBW-1:0] mx, my;
  logic              v2, op2;
  logic [GIW-1:0]    wrow2, wcol2;
  logic [EW-1:0]     elev2;
  logic [XW-1:0]     x2, y2, qx2, qy2;
  logic [SBW-1:0]    rx2, ry2;

  assign qx0 = px1[K +: XW];
  assign qy0 = py1[K +: XW];
  assign mx  = {{SBW{1'b0}}, qx0} * {{XW{1'b0}}, s_c};
  assign my  = {{SBW{1'b0}}, qy0} * {{XW{1'b0}}, s_c};
  assign rx0 = x1 - mx[XW-1:0];
  assign ry0 = y1 - my[XW-1:0];
  assign sx  = XW'(s_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2   <= op1;
      wrow2 <= wrow1;
      wcol2 <= wcol1;
      elev2 <= elev1;
      x2    <= x1;
      y2    <= y1;
      qx2   <= (rx0 >= sx) ? qx0 + XW'(1) : qx0;
      rx2   <= (rx0 >= sx) ? SBW'(rx0 - sx) : SBW'(rx0);
      qy2   <= (ry0 >= sx) ? qy0 + XW'(1) : qy0;
      ry2   <= (ry0 >= sx) ? SBW'(ry0 - sx) : SBW'(ry0);
    end
  end

  // Stage 3: clamp neighbours, address the parity banks, write grid samples.
  function automatic logic [IW-1:0] clip(logic [IW-1:0] v, logic [IW-1:0] m);
    return (v > m) ? m : v;
  endfunction

  function automatic logic [BAW-1:0] bank_addr(logic [IW-1:0] row, logic [IW-1:0] col);
    logic [IW-1:0] hr;
    logic [IW-1:0] hc;
    hr = row >> 1;
    hc = col >> 1;
    return BAW'(hr) * BAW'(HALF) + BAW'(hc);
  endfunction

  logic [IW-1:0]  xa, xb, ya, yb, wr_r, wr_c;
  logic [BAW-1:0] rd_addr [4];
  logic [EW-1:0]  rd_data [4];
  logic           wr_en;
  logic [1:0]     wr_bank;
  logic [BAW-1:0] wr_addr;

  assign xa = clip(IW'(qx2), smax);
  assign xb = clip(IW'(qx2) + IW'(rx2 != '0), smax);
  assign ya = clip(IW'(qy2), smax);
  assign yb = clip(IW'(qy2) + IW'(ry2 != '0), smax);

  // Rows ya and yb differ by at most one, so each bank serves one of them.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = bank_addr((ya[0] == b[1]) ? ya : yb, (xa[0] == b[0]) ? xa : xb);
    end
  end

  assign wr_r    = IW'(wrow2);
  assign wr_c    = IW'(wcol2);
  assign wr_bank = {wrow2[0], wcol2[0]};
  assign wr_addr = bank_addr(wr_r, wr_c);
  assign wr_en   = en && v2 && (op2 == OPC_WRITE) &&
                   (wr_r < IW'(MAX_SIDE)) && (wr_c < IW'(MAX_SIDE));

  hbu_grid #(.DEPTH(BDEPTH)) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bank (wr_bank),
    .wr_addr (wr_addr),
    .wr_data (elev2),
    .rd_en   (en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic           v3;
  logic           pya, pyb, pxa, pxb;
  logic [SBW-1:0] rx3, ry3;
  logic [XW-1:0]  x3, y3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2 && (op2 == OPC_QUERY);
    end
    if (en) begin
      pya <= ya[0];
      pyb <= yb[0];
      pxa <= xa[0];
      pxb <= xb[0];
      rx3 <= rx2;
      ry3 <= ry2;
      x3  <= x2;
      y3  <= y2;
    end
  end

  // Stage 4: horizontal blends of the upper and lower neighbour pairs.
  // Products are taken at full result width, so sign handling is exact.
  logic [EW-1:0]  p1, p2, p3, p4;
  logic [WA-1:0]  wl, wr;
  logic [NW-1:0]  mn, ssn;
  logic           v4;
  logic [WA-1:0]  a4, b4;
  logic [NW-1:0]  ms4;
  logic [SBW-1:0] ry4;
  logic [XW-1:0]  x4, y4;

  assign p1  = rd_data[{pya, pxa}];
  assign p2  = rd_data[{pya, pxb}];
  assign p3  = rd_data[{pyb, pxa}];
  assign p4  = rd_data[{pyb, pxb}];
  assign wl  = WA'(s_c - rx3);
  assign wr  = WA'(rx3);
  assign mn  = {{(NW-EW){cfg_q.min_elevation[EW-1]}}, cfg_q.min_elevation};
  assign ssn = NW'(s2_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      a4  <= {{(WA-EW){p1[EW-1]}}, p1} * wl + {{(WA-EW){p2[EW-1]}}, p2} * wr;
      b4  <= {{(WA-EW){p3[EW-1]}}, p3} * wl + {{(WA-EW){p4[EW-1]}}, p4} * wr;
      ms4 <= mn * ssn;
      ry4 <= ry3;
      x4  <= x3;
      y4  <= y3;
    end
  end

  // Stage 5: vertical blend and offset removal.
  logic          v5;
  logic [NW-1:0] n5;
  logic [XW-1:0] x5, y5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      n5 <= {{(NW-WA){a4[WA-1]}}, a4} * NW'(s_c - ry4)
          + {{(NW-WA){b4[WA-1]}}, b4} * NW'(ry4) - ms4;
      x5 <= x4;
      y5 <= y4;
    end
  end

  // Stage 6: scale product split into upper signed and lower unsigned halves.
  logic [11:0]      sc_hi, sc_lo;
  logic             v6;
  logic [PHW-1:0]   ph6;
  logic [PLW_M-1:0] pl6;
  logic [XW-1:0]    x6, y6;

  assign sc_hi = cfg_q.vertical_scale[23:12];
  assign sc_lo = cfg_q.vertical_scale[11:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
    if (en) begin
      ph6 <= {{(PHW-NW){n5[NW-1]}}, n5} * {{(PHW-12){sc_hi[11]}}, sc_hi};
      pl6 <= {{(PLW_M-NW){n5[NW-1]}}, n5} * PLW_M'(sc_lo);
      x6  <= x5;
      y6  <= y5;
    end
  end

  // Stage 7: combine partial products.
  logic          v7;
  logic [PW-1:0] prod7;
  logic [XW-1:0] x7, y7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
    if (en) begin
      prod7 <= ({{(PW-PHW){ph6[PHW-1]}}, ph6} << 12)
             + {{(PW-PLW_M){pl6[PLW_M-1]}}, pl6};
      x7    <= x6;
      y7    <= y6;
    end
  end

  // Round half away from zero on the magnitude; the 2^16 part of the
  // divisor is a shift, the square of the factor goes to the divider.
  logic          neg7;
  logic [PW-1:0] mag7, rnd7;
  logic          dv;
  logic [31:0]   dq;
  logic          dovf;
  logic [DPL-1:0] dpl;

  assign neg7 = prod7[PW-1];
  assign mag7 = neg7 ? -prod7 : prod7;
  assign rnd7 = mag7 + (PW'(s2_c) << 15);

  hbu_div #(.TW(TW), .DW(S2W), .PLW(DPL), .QW(32)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .in_num    (rnd7[PW-1:16]),
    .in_den    (s2_c),
    .in_pl     ({neg7, x7, y7}),
    .out_valid (dv),
    .out_quo   (dq),
    .out_ovf   (dovf),
    .out_pl    (dpl)
  );

  // Output register: sign, saturation and row mirroring.
  logic          sgn;
  logic [31:0]   hval;
  logic [XW-1:0] dx, dy;

  assign sgn  = dpl[DPL-1] ^ cfg_q.negate_height;
  assign dx   = dpl[2*XW-1:XW];
  assign dy   = dpl[XW-1:0];

  always_comb begin
    if (!sgn) begin
      hval = (dovf || dq[31]) ? 32'h7FFF_FFFF : dq;
    end else begin
      hval = (dovf || (dq[31] && (dq[30:0] != '0))) ? 32'h8000_0000 : -dq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv;
    end
    if (en) begin
      rsp.height  <= hval;
      rsp.out_col <= dx;
      rsp.out_row <= cfg_q.flip_rows ? cfg_q.vertex_count[XW-1:0] - XW'(1) - dy : dy;
    end
  end

endmodule

FILE: src/hbu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hbu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16641
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/hbu_grid.sv
// Elevation grid split into four parity banks (row parity, column parity),
// so that all four bilinear neighbours are read in the same cycle. Uses hbu_ram.
module hbu_grid import hbu_pkg::*; #(
  parameter int DEPTH = 16641
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [1:0]                              wr_bank,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [EW-1:0]                           wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr [4],
  output logic [EW-1:0]                           rd_data [4]
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic bank_wr;
    assign bank_wr = wr_en && (wr_bank == 2'(b));
    hbu_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
      .clk     (clk),
      .wr_en   (bank_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr[b]),
      .rd_data (rd_data[b])
    );
  end

endmodule

FILE: src/hbu_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit. Depends on hbu_pkg.
module hbu_div import hbu_pkg::*; #(
  parameter int TW  = 46,
  parameter int DW  = 10,
  parameter int PLW = 25,
  parameter int QW  = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [TW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [PLW-1:0] in_pl,
  output logic           out_valid,
  output logic [QW-1:0]  out_quo,
  output logic           out_ovf,
  output logic [PLW-1:0] out_pl
);

  localparam int CW = (TW > DW + QW ? TW : DW + QW) + 1;

  logic           vld [QW+1];
  logic [CW-1:0]  rem [QW+1];
  logic [QW-1:0]  quo [QW+1];
  logic           ovf [QW+1];
  logic [DW-1:0]  den [QW+1];
  logic [PLW-1:0] pl  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      rem[0] <= CW'(in_num);
      quo[0] <= '0;
      ovf[0] <= 1'b0;
      den[0] <= in_den;
      pl[0]  <= in_pl;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [CW-1:0] trial;
    logic          ge;
    logic          big;
    assign trial = CW'(den[k-1]) << (QW - k);
    assign ge    = rem[k-1] >= trial;
    if (k == 1) begin : g_first
      assign big = rem[0] >= (CW'(den[0]) << QW);
    end else begin : g_rest
      assign big = ovf[k-1];
    end

    // Earlier stages only set higher bits, so this bit is still clear.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        rem[k] <= ge ? rem[k-1] - trial : rem[k-1];
        quo[k] <= quo[k-1] | (QW'(ge) << (QW - k));
        ovf[k] <= big;
        den[k] <= den[k-1];
        pl[k]  <= pl[k-1];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_ovf   = ovf[QW];
  assign out_pl    = pl[QW];

endmodule
